// ===== hw/rtl/chtab_pkg.sv =====
// Shared constants and codes for the connection handle table.
`timescale 1ns / 1ps
`default_nettype none

package chtab_pkg;

    localparam int TABLE_SIZE_DEF = 1024;
    localparam int FULL_MARGIN    = 10;
    localparam int SERIAL_INIT    = 1000;

    localparam int OP_W     = 2;
    localparam int SOCK_W   = 16;
    localparam int HIDX_W   = 12;
    localparam int HSER_W   = 10;
    localparam int STATUS_W = 2;
    localparam int OIDX_W   = 10;
    localparam int OSER_W   = 10;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
    localparam logic [OP_W-1:0] OP_GET     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STALE = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/chtab_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module chtab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/connection_handle_table_top.sv =====
// Top level of the connection handle table: control, counters and result register.
//
// Usage:
//   Requests enter on s_tvalid/s_tready/s_tdata, one item each; each request
//   gives exactly one result item on m_tvalid/m_tready/m_tdata.
//   Ops: create takes a slot (free stack first, else the next fresh slot),
//   destroy releases a handle, get returns the stored socket.
//   An accepted request runs in the execute state, which registers its result
//   for m_tvalid; no new request is taken meanwhile. The entry and free stack
//   RAMs are read in the accept cycle and written back in the execute cycle.
//   Accesses never overlap, since the next read happens after the write-back.
//   s_tready is low in the execute cycle; a result waiting in the output
//   register does not block the next accept, but the execute cycle holds
//   until the output register is free, so a stalled receiver backs up here.
//   Reset: counters clear, serial counter starts at 1000 mod TABLE_SIZE.
//   The entry RAM needs no clearing pass: a high-water mark of fresh slots
//   makes every entry at or above it read as empty, so the block is ready
//   right after reset.
`timescale 1ns / 1ps
`default_nettype none

module connection_handle_table_top #(
    parameter int TABLE_SIZE = chtab_pkg::TABLE_SIZE_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // op[1:0], socket_id[17:2], handle_index[29:18], handle_serial[39:30]
    input  wire logic [chtab_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // status[1:0], slot_index[11:2], slot_serial[21:12], socket_out[37:22], zeros above
    output logic      [chtab_pkg::M_TDATA_W-1:0] m_tdata
);

    import chtab_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int CNT_W   = $clog2(TABLE_SIZE + 1);
    localparam int ENT_W   = SOCK_W + IDX_W;
    localparam int SCMP_W  = (IDX_W > HSER_W) ? IDX_W : HSER_W;
    localparam int CHK_W   = CNT_W + 1;
    localparam int HCMP_W  = (CNT_W > HIDX_W) ? CNT_W + 1 : HIDX_W + 1;
    localparam int SER_RST = SERIAL_INIT % TABLE_SIZE;

    localparam logic FSM_IDLE = 1'b0;
    localparam logic FSM_EXEC = 1'b1;

    logic                state_reg, state_next;
    logic [OP_W-1:0]     op_reg;
    logic [SOCK_W-1:0]   sock_reg;
    logic [HIDX_W-1:0]   hidx_reg;
    logic [HSER_W-1:0]   hser_reg;
    logic [CNT_W-1:0]    in_use_reg, in_use_next;
    logic [CNT_W-1:0]    free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0]    hw_reg, hw_next;
    logic [IDX_W-1:0]    serial_reg, serial_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                accept;
    logic                exec_go;
    logic [OP_W-1:0]     in_op;
    logic [SOCK_W-1:0]   in_sock;
    logic [HIDX_W-1:0]   in_hidx;
    logic [HSER_W-1:0]   in_hser;

    logic                ent_wr_en;
    logic [IDX_W-1:0]    ent_wr_addr;
    logic [ENT_W-1:0]    ent_wr_data;
    logic [ENT_W-1:0]    ent_rd_data;
    logic                stk_wr_en;
    logic [IDX_W-1:0]    stk_wr_addr;
    logic [IDX_W-1:0]    stk_rd_addr;
    logic [IDX_W-1:0]    stk_rd_data;
    logic [CNT_W-1:0]    free_top;

    logic                range_ok;
    logic                fresh;
    logic [SOCK_W-1:0]   ent_sock;
    logic [IDX_W-1:0]    ent_ser;
    logic                handle_ok;
    logic [STATUS_W-1:0] chk_status;
    logic                room;
    logic [IDX_W-1:0]    slot;
    logic [IDX_W-1:0]    serial_inc;

    logic [STATUS_W-1:0] r_status;
    logic [OIDX_W-1:0]   r_idx;
    logic [OSER_W-1:0]   r_ser;
    logic [SOCK_W-1:0]   r_sock;

    assign in_op   = s_tdata[OP_W-1:0];
    assign in_sock = s_tdata[OP_W+SOCK_W-1:OP_W];
    assign in_hidx = s_tdata[OP_W+SOCK_W+HIDX_W-1:OP_W+SOCK_W];
    assign in_hser = s_tdata[OP_W+SOCK_W+HIDX_W+HSER_W-1:OP_W+SOCK_W+HIDX_W];

    assign s_tready = (state_reg == FSM_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign exec_go  = (state_reg == FSM_EXEC) && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign free_top    = free_cnt_reg - CNT_W'(1);
    assign stk_rd_addr = free_top[IDX_W-1:0];

    chtab_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_SIZE)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_en   (accept),
        .rd_addr (in_hidx[IDX_W-1:0]),
        .rd_data (ent_rd_data)
    );

    chtab_ram #(
        .WIDTH (IDX_W),
        .DEPTH (TABLE_SIZE)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (hidx_reg[IDX_W-1:0]),
        .rd_en   (accept),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // handle check against the entry read in the accept cycle
    always_comb
    begin
        range_ok   = (HCMP_W'(hidx_reg) < HCMP_W'(TABLE_SIZE));
        fresh      = (HCMP_W'(hidx_reg) >= HCMP_W'(hw_reg));
        ent_sock   = fresh ? '0 : ent_rd_data[ENT_W-1:IDX_W];
        ent_ser    = fresh ? '0 : ent_rd_data[IDX_W-1:0];
        handle_ok  = (SCMP_W'(ent_ser) == SCMP_W'(hser_reg)) && (ent_sock != '0);
        if (!range_ok)
        begin
            chk_status = ST_RANGE;
        end
        else if (!handle_ok)
        begin
            chk_status = ST_STALE;
        end
        else
        begin
            chk_status = ST_OK;
        end
        room       = ((CHK_W'(in_use_reg) + CHK_W'(FULL_MARGIN)) < CHK_W'(TABLE_SIZE));
        slot       = (free_cnt_reg != '0) ? stk_rd_data : in_use_reg[IDX_W-1:0];
        serial_inc = (serial_reg == IDX_W'(TABLE_SIZE - 1)) ? '0 : serial_reg + IDX_W'(1);
    end

    always_comb
    begin
        state_next    = state_reg;
        in_use_next   = in_use_reg;
        free_cnt_next = free_cnt_reg;
        hw_next       = hw_reg;
        serial_next   = serial_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        ent_wr_en     = 1'b0;
        ent_wr_addr   = hidx_reg[IDX_W-1:0];
        ent_wr_data   = '0;
        stk_wr_en     = 1'b0;
        stk_wr_addr   = free_cnt_reg[IDX_W-1:0];
        r_status      = ST_OK;
        r_idx         = '0;
        r_ser         = '0;
        r_sock        = '0;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (exec_go)
                begin
                    case (op_reg)
                        OP_CREATE:
                        begin
                            if (!room)
                            begin
                                r_status = ST_FULL;
                            end
                            else
                            begin
                                if (free_cnt_reg != '0)
                                begin
                                    free_cnt_next = free_top;
                                end
                                else
                                begin
                                    hw_next = hw_reg + CNT_W'(1);
                                end
                                serial_next = serial_inc;
                                ent_wr_en   = 1'b1;
                                ent_wr_addr = slot;
                                ent_wr_data = {sock_reg, serial_inc};
                                in_use_next = in_use_reg + CNT_W'(1);
                                r_idx       = OIDX_W'(slot);
                                r_ser       = OSER_W'(serial_inc);
                            end
                        end
                        OP_DESTROY:
                        begin
                            r_status = chk_status;
                            if (chk_status == ST_OK)
                            begin
                                ent_wr_en = 1'b1;
                                if (free_cnt_reg < CNT_W'(TABLE_SIZE))
                                begin
                                    stk_wr_en     = 1'b1;
                                    free_cnt_next = free_cnt_reg + CNT_W'(1);
                                end
                                if (in_use_reg != '0)
                                begin
                                    in_use_next = in_use_reg - CNT_W'(1);
                                end
                            end
                        end
                        OP_GET:
                        begin
                            r_status = chk_status;
                            if (chk_status == ST_OK)
                            begin
                                r_sock = ent_sock;
                            end
                        end
                        default:
                        begin
                            r_status = ST_OK;
                        end
                    endcase
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({r_sock, r_ser, r_idx, r_status});
                    state_next   = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FSM_IDLE;
            in_use_reg   <= '0;
            free_cnt_reg <= '0;
            hw_reg       <= '0;
            serial_reg   <= IDX_W'(SER_RST);
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_use_reg   <= in_use_next;
            free_cnt_reg <= free_cnt_next;
            hw_reg       <= hw_next;
            serial_reg   <= serial_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        if (accept)
        begin
            op_reg   <= in_op;
            sock_reg <= in_sock;
            hidx_reg <= in_hidx;
            hser_reg <= in_hser;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/chtab_checker.sv =====
// Port-level checks for the connection handle table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module chtab_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [chtab_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [chtab_pkg::M_TDATA_W-1:0] m_tdata
);

    import chtab_pkg::*;

    // one item in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accept in execute cycle");

    // a new result only appears after an execute cycle
    a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without execute cycle");

    // failed requests carry no slot, serial or socket
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] != ST_OK)) |-> (m_tdata[M_TDATA_W-1:2] == '0))
        else $error("error result with payload");

    // create and get never both report: socket and slot fields exclusive
    a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[37:22] != '0)) |-> (m_tdata[21:2] == '0))
        else $error("socket and slot both set");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind connection_handle_table_top chtab_checker u_chtab_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
